// File: rtl/ordered_list_engine_top_defines.svh
// Assertion helpers
`ifndef ORDERED_LIST_ENGINE_TOP_DEFINES_SVH
`define ORDERED_LIST_ENGINE_TOP_DEFINES_SVH
`define OLE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define OLE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: rtl/ole_pkg.sv
`default_nettype none
package ole_pkg;
   typedef enum logic [2:0] {
      OP_INS_HEAD = 3'd0,
      OP_INS_TAIL = 3'd1,
      OP_INS_POS  = 3'd2,
      OP_DELETE   = 3'd3,
      OP_SEARCH   = 3'd4,
      OP_REVERSE  = 3'd5
   } op_type;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_POS   = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   // memory port bundle from controller to slot store
   typedef struct packed {
      logic       rd_en;
      logic [7:0] rd_addr;
      logic       wr_val_en;
      logic       wr_lnk_en;
      logic [7:0] wr_addr;
      logic [31:0] wr_val;
      logic [7:0] wr_lnk;
   } mem_cmd_type;
endpackage
`default_nettype wire

// File: rtl/ole_slot_mem.sv
`default_nettype none
module ole_slot_mem
   import ole_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  wire logic        clock,
   input  wire mem_cmd_type cmd,
   output logic [31:0]      rd_val,
   output logic [7:0]       rd_lnk
);
   logic [31:0] val_mem [DEPTH];
   logic [7:0]  lnk_mem [DEPTH];
   logic [31:0] rd_val_ff;
   logic [7:0]  rd_lnk_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_val_en) begin
         val_mem[cmd.wr_addr] <= cmd.wr_val;
      end
      if (cmd.wr_lnk_en) begin
         lnk_mem[cmd.wr_addr] <= cmd.wr_lnk;
      end
      if (cmd.rd_en) begin
         rd_val_ff <= val_mem[cmd.rd_addr];
         rd_lnk_ff <= lnk_mem[cmd.rd_addr];
      end
   end

   assign rd_val = rd_val_ff;
   assign rd_lnk = rd_lnk_ff;
endmodule
`default_nettype wire

// File: rtl/ordered_list_engine_top.sv
// Flow: status-only requests finish without slot-memory access; inserts do a
// free-slot scan then link walk; delete, search and reverse do
// one slot-memory read per list entry plus write-back.
// Throughput: one request at a time; next request taken once the result leaves.
// Reset: synchronous, clears list head, count, in-use bits and handshakes;
// slot memories are not cleared.
`default_nettype none
`include "ordered_list_engine_top_defines.svh"
module ordered_list_engine_top
   import ole_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // req_type[2:0], item_value[34:3], target_position[43:35]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata   // status[2:0], found_position[11:3], list_size[20:12]
);
   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_WALK, S_WAIT, S_CHECK, S_LINK, S_REV, S_DONE
   } state_type;

   state_type   state_ff, state_in;
   logic [2:0]  op_ff, op_in;
   logic [31:0] val_ff, val_in;
   logic [8:0]  pos_ff, pos_in;
   logic [8:0]  cnt_ff, cnt_in;
   logic [7:0]  head_ff, head_in;
   logic [8:0]  idx_ff, idx_in;
   logic [7:0]  cur_ff, cur_in;
   logic [7:0]  prev_ff, prev_in;
   logic [7:0]  new_ff, new_in;
   logic [2:0]  st_ff, st_in;
   logic [8:0]  fnd_ff, fnd_in;
   logic        vld_ff, vld_in;
   logic [CAPACITY-1:0] use_ff, use_in;
   mem_cmd_type cmd;
   logic [31:0] rd_val;
   logic [7:0]  rd_lnk;
   logic [2:0]  r_op;
   logic [8:0]  r_pos;

   assign r_op  = req_tdata[2:0];
   assign r_pos = req_tdata[43:35];
   assign req_tready = (state_ff == S_IDLE) && !vld_ff;
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {3'b000, cnt_ff, fnd_ff, st_ff};

   ole_slot_mem #(.DEPTH(CAPACITY)) u_mem (
      .clock (clock), .cmd (cmd), .rd_val (rd_val), .rd_lnk (rd_lnk)
   );

   always_comb begin
      state_in = state_ff; op_in = op_ff; val_in = val_ff; pos_in = pos_ff;
      cnt_in = cnt_ff; head_in = head_ff; idx_in = idx_ff; cur_in = cur_ff;
      prev_in = prev_ff; new_in = new_ff; st_in = st_ff; fnd_in = fnd_ff;
      vld_in = vld_ff; use_in = use_ff;
      cmd = '0;
      if (vld_ff && rsp_tready) begin
         vld_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in = r_op; val_in = req_tdata[34:3]; fnd_in = '0; st_in = ST_OK;
               idx_in = 9'd1; cur_in = head_ff; prev_in = head_ff; new_in = '0;
               state_in = S_DONE;
               case (r_op) inside
                  OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
                     pos_in = (r_op == OP_INS_HEAD) ? 9'd1 :
                              (r_op == OP_INS_TAIL) ? cnt_ff + 9'd1 : r_pos;
                     if (r_op == OP_INS_POS && (r_pos == 9'd0 || r_pos > cnt_ff + 9'd1))
                        st_in = ST_BAD_POS;
                     else if (cnt_ff == 9'(CAPACITY))
                        st_in = ST_FULL;
                     else
                        state_in = S_SCAN;
                  end
                  OP_DELETE, OP_SEARCH: begin
                     if (cnt_ff == 9'd0)
                        st_in = (r_op == OP_DELETE) ? ST_EMPTY : ST_NOT_FOUND;
                     else begin
                        cmd.rd_en = 1'b1; cmd.rd_addr = head_ff; state_in = S_CHECK;
                     end
                  end
                  OP_REVERSE: begin
                     prev_in = '0;
                     if (cnt_ff != 9'd0) begin
                        cmd.rd_en = 1'b1; cmd.rd_addr = head_ff; state_in = S_REV;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            if (!use_ff[new_ff]) begin
               // new slot found; position 1 links straight in
               cmd.wr_val_en = 1'b1; cmd.wr_addr = new_ff; cmd.wr_val = val_ff;
               use_in[new_ff] = 1'b1;
               if (pos_ff == 9'd1) begin
                  cmd.wr_lnk_en = 1'b1; cmd.wr_lnk = head_ff;
                  head_in = new_ff; cnt_in = cnt_ff + 9'd1; state_in = S_DONE;
               end else if (pos_ff == 9'd2) begin
                  cmd.rd_en = 1'b1; cmd.rd_addr = head_ff; state_in = S_LINK;
               end else begin
                  cmd.rd_en = 1'b1; cmd.rd_addr = head_ff; state_in = S_WALK;
               end
            end else begin
               new_in = new_ff + 8'd1;
            end
         end
         S_WALK: begin
            // cur_ff is slot at idx_ff; rd_lnk is its successor
            cur_in = rd_lnk; idx_in = idx_ff + 9'd1;
            cmd.rd_en = 1'b1; cmd.rd_addr = rd_lnk;
            if (idx_ff + 9'd2 == pos_ff) state_in = S_LINK;
         end
         S_LINK: begin
            cmd.wr_lnk_en = 1'b1; cmd.wr_addr = new_ff; cmd.wr_lnk = rd_lnk;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            cmd.wr_lnk_en = 1'b1; cmd.wr_addr = cur_ff; cmd.wr_lnk = new_ff;
            cnt_in = cnt_ff + 9'd1; state_in = S_DONE;
         end
         S_CHECK: begin
            if (rd_val == val_ff) begin
               if (op_ff == OP_SEARCH) begin
                  fnd_in = idx_ff;
               end else begin
                  if (idx_ff == 9'd1) head_in = rd_lnk;
                  else begin
                     cmd.wr_lnk_en = 1'b1; cmd.wr_addr = prev_ff; cmd.wr_lnk = rd_lnk;
                  end
                  use_in[cur_ff] = 1'b0; cnt_in = cnt_ff - 9'd1;
               end
               state_in = S_DONE;
            end else if (idx_ff == cnt_ff) begin
               st_in = ST_NOT_FOUND; state_in = S_DONE;
            end else begin
               prev_in = cur_ff; cur_in = rd_lnk; idx_in = idx_ff + 9'd1;
               cmd.rd_en = 1'b1; cmd.rd_addr = rd_lnk;
            end
         end
         S_REV: begin
            cmd.wr_lnk_en = 1'b1; cmd.wr_addr = cur_ff; cmd.wr_lnk = prev_ff;
            prev_in = cur_ff; cur_in = rd_lnk; idx_in = idx_ff + 9'd1;
            if (idx_ff == cnt_ff) begin
               head_in = cur_ff; state_in = S_DONE;
            end else begin
               cmd.rd_en = 1'b1; cmd.rd_addr = rd_lnk;
            end
         end
         S_DONE: begin
            vld_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; head_ff <= '0; vld_ff <= 1'b0; use_ff <= '0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; head_ff <= head_in;
         vld_ff <= vld_in; use_ff <= use_in;
      end
      op_ff <= op_in; val_ff <= val_in; pos_ff <= pos_in; idx_ff <= idx_in;
      cur_ff <= cur_in; prev_ff <= prev_in; new_ff <= new_in; st_ff <= st_in;
      fnd_ff <= fnd_in;
   end

   `OLE_ASSERT_IMP(a_cnt_max, clock, reset, 1'b1, cnt_ff <= 9'(CAPACITY), "count overflow")
   `OLE_ASSERT_IMP(a_cnt_pop, clock, reset, state_ff == S_IDLE, $countones(use_ff) == 32'(cnt_ff), "in-use mismatch")
   `OLE_ASSERT_NXT(a_rsp_hold, clock, reset, vld_ff && !rsp_tready, vld_ff && $stable(rsp_tdata), "result lost")
   `OLE_ASSERT_IMP(a_no_walk_rsp, clock, reset, state_ff != S_IDLE, !req_tready, "ready while busy")
endmodule
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
module tb
   import ole_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = 256;

   typedef struct packed {
      logic [8:0] size;
      logic [8:0] found;
      logic [2:0] status;
   } list_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   always #6 clock = ~clock;

   ordered_list_engine_top #(.CAPACITY(CAP)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // shadow list: slot memories plus head and count
   logic [31:0] shadow_val [CAP];
   logic [7:0]  shadow_link [CAP];
   logic        shadow_used [CAP];
   logic [7:0]  shadow_head = '0;
   int          shadow_count = 0;
   list_result_type pending_results [$];
   int          fail_count = 0;
   bit          draining = 1'b0;

   function automatic logic [7:0] slot_of(int pos);
      logic [7:0] s;
      s = shadow_head;
      for (int i = 1; i < pos; i++) s = shadow_link[s];
      return s;
   endfunction

   function automatic logic [2:0] link_in(logic [31:0] v, int pos);
      int n;
      logic [7:0] p;
      if (shadow_count >= CAP) return ST_FULL;
      n = 0;
      while (shadow_used[n]) n++;
      shadow_val[n] = v;
      shadow_used[n] = 1'b1;
      if (pos == 1) begin
         shadow_link[n] = shadow_head;
         shadow_head = n[7:0];
      end else begin
         p = slot_of(pos - 1);
         shadow_link[n] = shadow_link[p];
         shadow_link[p] = n[7:0];
      end
      shadow_count++;
      return ST_OK;
   endfunction

   function automatic list_result_type predict_list_op(logic [2:0] op, logic [31:0] v,
                                                       logic [8:0] pos);
      list_result_type r;
      logic [7:0] cur, prv, nx;
      r = '0;
      r.status = ST_OK;
      case (op)
         OP_INS_HEAD: r.status = link_in(v, 1);
         OP_INS_TAIL: r.status = link_in(v, shadow_count + 1);
         OP_INS_POS: begin
            if (pos == 0 || int'(pos) > shadow_count + 1) r.status = ST_BAD_POS;
            else r.status = link_in(v, pos);
         end
         OP_DELETE: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.status = ST_NOT_FOUND;
               cur = shadow_head;
               prv = shadow_head;
               for (int i = 1; i <= shadow_count; i++) begin
                  if (shadow_val[cur] == v) begin
                     if (i == 1) shadow_head = shadow_link[cur];
                     else shadow_link[prv] = shadow_link[cur];
                     shadow_used[cur] = 1'b0;
                     shadow_count--;
                     r.status = ST_OK;
                     break;
                  end
                  prv = cur;
                  cur = shadow_link[cur];
               end
            end
         end
         OP_SEARCH: begin
            r.status = ST_NOT_FOUND;
            cur = shadow_head;
            for (int i = 1; i <= shadow_count; i++) begin
               if (shadow_val[cur] == v) begin
                  r.status = ST_OK;
                  r.found = i[8:0];
                  break;
               end
               cur = shadow_link[cur];
            end
         end
         OP_REVERSE: begin
            if (shadow_count > 0) begin
               prv = '0;
               cur = shadow_head;
               for (int i = 0; i < shadow_count; i++) begin
                  nx = shadow_link[cur];
                  shadow_link[cur] = prv;
                  prv = cur;
                  cur = nx;
               end
               shadow_head = prv;
            end
         end
         default: ;
      endcase
      r.size = shadow_count[8:0];
      return r;
   endfunction

   task automatic send_request(logic [2:0] op, logic [31:0] v, logic [8:0] pos);
      int gap;
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, pos, v, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(predict_list_op(op, v, pos));
   endtask

   // result side: random stall before each transaction, none while draining
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = draining ? 0 : $urandom_range(0, 8);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      list_result_type act, exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         act = rsp_tdata[20:0];
         if (pending_results.size() == 0) begin
            $error("unexpected result %h", rsp_tdata);
            fail_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (act.status !== exp_r.status) begin
               $error("status exp %0d act %0d", exp_r.status, act.status);
               fail_count++;
            end
            if (act.found !== exp_r.found) begin
               $error("found_position exp %0d act %0d", exp_r.found, act.found);
               fail_count++;
            end
            if (act.size !== exp_r.size) begin
               $error("list_size exp %0d act %0d", exp_r.size, act.size);
               fail_count++;
            end
         end
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom();
         default: return $urandom_range(0, 15);
      endcase
   endfunction

   task automatic test_empty_list();
      send_request(OP_DELETE, 32'd5, 9'd0);
      send_request(OP_SEARCH, 32'd5, 9'd0);
      send_request(OP_REVERSE, 32'd0, 9'd0);
      send_request(3'd6, 32'hffff_ffff, 9'h1ff);
      send_request(3'd7, 32'd0, 9'd0);
      send_request(OP_INS_POS, 32'd1, 9'd0);
      send_request(OP_INS_POS, 32'd1, 9'd2);
   endtask

   task automatic test_basic_ops();
      send_request(OP_INS_POS, 32'h8000_0000, 9'd1);
      send_request(OP_INS_HEAD, 32'h7fff_ffff, 9'd0);
      send_request(OP_INS_TAIL, 32'hffff_ffff, 9'h1ff);
      send_request(OP_INS_POS, 32'd0, 9'd4);
      send_request(OP_INS_POS, 32'd3, 9'd2);
      send_request(OP_INS_POS, 32'd9, 9'd7);
      send_request(OP_SEARCH, 32'd0, 9'd0);
      send_request(OP_SEARCH, 32'h8000_0000, 9'd0);
      send_request(OP_REVERSE, 32'd0, 9'd0);
      send_request(OP_SEARCH, 32'h7fff_ffff, 9'd0);
      send_request(OP_DELETE, 32'h1234, 9'd0);
      send_request(OP_DELETE, 32'h7fff_ffff, 9'd0);
      send_request(OP_DELETE, 32'hffff_ffff, 9'd0);
      send_request(OP_INS_HEAD, 32'd3, 9'd0);
      send_request(OP_DELETE, 32'd3, 9'd0);
      send_request(OP_SEARCH, 32'd3, 9'd0);
   endtask

   task automatic test_full_list();
      while (shadow_count < CAP) send_request(OP_INS_TAIL, $urandom_range(0, 40), 9'd0);
      send_request(OP_INS_HEAD, 32'd1, 9'd0);
      send_request(OP_INS_TAIL, 32'd1, 9'd0);
      send_request(OP_INS_POS, 32'd1, 9'd1);
      send_request(OP_INS_POS, 32'd1, 9'h1ff);
      send_request(OP_REVERSE, 32'd0, 9'd0);
      send_request(OP_SEARCH, 32'hdead_beef, 9'd0);
      for (int i = 0; i < 8; i++) send_request(OP_DELETE, $urandom_range(0, 40), 9'd0);
      while (shadow_count > 0) send_request(OP_DELETE, shadow_val[shadow_head], 9'd0);
   endtask

   task automatic test_random_mix();
      logic [2:0] op;
      logic [8:0] pos;
      for (int n = 0; n < 860; n++) begin
         op = 3'($urandom_range(0, 7));
         if (shadow_count < 12 && $urandom_range(0, 1)) op = OP_INS_TAIL;
         if (shadow_count > 60 && $urandom_range(0, 1)) op = OP_DELETE;
         case ($urandom_range(0, 7))
            0: pos = 9'($urandom());
            1: pos = 9'd0;
            2: pos = 9'(shadow_count + 2);
            default: pos = 9'($urandom_range(1, shadow_count + 1));
         endcase
         send_request(op, pick_value(), pos);
      end
   endtask

   initial begin
      for (int i = 0; i < CAP; i++) shadow_used[i] = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_basic_ops();
      test_full_list();
      test_random_mix();
      req_tvalid <= 1'b0;
      draining = 1'b1;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("ordered_list_engine_top verification clean");
      end else begin
         $display("ordered_list_engine_top verification failed");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("ordered_list_engine_top verification failed");
      $finish;
   end
endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/ole_pkg.sv
rtl/ole_slot_mem.sv
rtl/ordered_list_engine_top.sv
tb/tb.sv
